/* rtl/pfa_pkg.sv */
// Package for the paged frame allocator: sizes, codes and shared types.
// Used by every module under rtl.
package pfa_pkg;
   localparam int MemoryBytesDef = 1024;
   localparam int PageBytesDef = 32;
   localparam int MaxProcBytesDef = 256;
   localparam int MaxProcsDef = 128;

   localparam logic [1:0] ACT_CREATE = 2'd0;
   localparam logic [1:0] ACT_LIST = 2'd1;
   localparam logic [1:0] ACT_QUERY = 2'd2;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_DUP = 3'd1;
   localparam logic [2:0] ST_LARGE = 3'd2;
   localparam logic [2:0] ST_NOMEM = 3'd3;
   localparam logic [2:0] ST_FULL = 3'd4;
   localparam logic [2:0] ST_NOTFOUND = 3'd5;

   typedef struct packed {
      logic [1:0] action;
      logic [15:0] pid;
      logic [15:0] size_bytes;
      logic [4:0] frame_index;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic has_entry;
      logic [2:0] page_number;
      logic [4:0] frame_number;
      logic [3:0] num_pages;
      logic frame_free;
      logic [15:0] owner_id;
      logic last;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_DECIDE, S_ALLOC, S_LIST, S_QUERY, S_EMIT
   } state_type;
endpackage

/* rtl/pfa_fifo.sv */
// Two-entry request queue between the front and back parts.
// Depends on pfa_pkg.
module pfa_fifo (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  pfa_pkg::req_type in_data,
   output logic out_valid,
   input  logic out_ready,
   output pfa_pkg::req_type out_data
);
   import pfa_pkg::*;
   req_type mem_ff [2];
   logic wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic push, pop;

   assign in_ready = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data = mem_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;

   always_comb begin
      wp_in = push ? ~wp_ff : wp_ff;
      rp_in = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wp_ff] <= in_data;
   end
endmodule

/* rtl/pfa_front.sv */
// Front part: accepts request words, drops unused action codes.
// Depends on pfa_pkg.
module pfa_front (
   input  logic req_tvalid,
   output logic req_tready,
   input  pfa_pkg::req_type req_item,
   output logic q_valid,
   input  logic q_ready,
   output pfa_pkg::req_type q_item
);
   import pfa_pkg::*;
   logic known;
   assign known = (req_item.action == ACT_CREATE) || (req_item.action == ACT_LIST)
      || (req_item.action == ACT_QUERY);
   // unknown codes are swallowed without a queue slot
   assign req_tready = q_ready || !known;
   assign q_valid = req_tvalid && known;
   assign q_item = req_item;
endmodule

/* rtl/pfa_back.sv */
// Back part: process table scan, frame stack and result sequencing.
// Depends on pfa_pkg.
module pfa_back #(
   parameter int MEMORY_BYTES = pfa_pkg::MemoryBytesDef,
   parameter int PAGE_BYTES = pfa_pkg::PageBytesDef,
   parameter int MAX_PROCESS_BYTES = pfa_pkg::MaxProcBytesDef,
   parameter int MAX_PROCESSES = pfa_pkg::MaxProcsDef
) (
   input  logic clock,
   input  logic reset,
   input  logic q_valid,
   output logic q_ready,
   input  pfa_pkg::req_type q_item,
   output logic rsp_valid,
   input  logic rsp_ready,
   output pfa_pkg::rsp_type rsp_item
);
   import pfa_pkg::*;
   localparam int NumFrames = MEMORY_BYTES / PAGE_BYTES;
   localparam int FW = (NumFrames > 1) ? $clog2(NumFrames) : 1;
   localparam int CW = $clog2(NumFrames + 1);
   localparam int MaxPages = (MAX_PROCESS_BYTES + PAGE_BYTES - 1) / PAGE_BYTES;
   localparam int PW = (MaxPages > 1) ? $clog2(MaxPages) : 1;
   localparam int PSW = $clog2(PAGE_BYTES);
   localparam int SW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
   localparam int PCW = $clog2(MAX_PROCESSES + 1);

   // frame stack, owner/page tables and process tables
   logic [FW-1:0] stack_ff [NumFrames];
   logic [NumFrames-1:0] isfree_ff;
   logic [15:0] owner_mem [NumFrames];
   logic [2:0] fpage_mem [NumFrames];
   logic [15:0] pid_mem [MAX_PROCESSES];
   logic [3:0] ppages_mem [MAX_PROCESSES];
   logic [FW-1:0] map_mem [MAX_PROCESSES * (1 << PW)];
   logic [CW-1:0] fcount_ff, fcount_in;
   logic [PCW-1:0] pcount_ff, pcount_in;

   state_type state_ff, state_in;
   req_type cur_ff;
   logic [SW-1:0] idx_ff, idx_in;
   logic hit_ff, hit_in;
   logic [SW-1:0] hslot_ff, hslot_in;
   logic [3:0] pages_ff, pages_in;
   logic [3:0] pg_ff, pg_in;
   rsp_type out_ff, out_in;
   logic ovalid_ff, ovalid_in;
   logic [15:0] pid_rd;
   logic [3:0] ppages_rd;
   logic [FW-1:0] map_rd;
   logic [15:0] own_rd;
   logic [2:0] fpg_rd;
   logic pop;
   logic [FW-1:0] top_frame;
   logic [16:0] pages_calc;
   logic [SW-1:0] map_slot;
   logic [FW-1:0] qry_idx;

   assign pages_calc = ({1'b0, cur_ff.size_bytes} + 17'(PAGE_BYTES - 1)) >> PSW;
   assign rsp_valid = ovalid_ff;
   assign rsp_item = out_ff;
   assign q_ready = (state_ff == S_IDLE);
   assign top_frame = stack_ff[FW'(fcount_ff - CW'(1))];
   assign map_slot = (state_ff == S_ALLOC) ? SW'(pcount_ff - PCW'(1)) : hslot_ff;
   // frame query address is taken from the incoming word while idle
   assign qry_idx = (state_ff == S_IDLE) ? q_item.frame_index[FW-1:0]
      : cur_ff.frame_index[FW-1:0];

   // synchronous reads, addressed by the scan index, the hit slot and page counter, or the query frame
   always_ff @(posedge clock) begin
      pid_rd <= pid_mem[idx_in];
      ppages_rd <= ppages_mem[hslot_in];
      map_rd <= map_mem[{hslot_in, pg_in[PW-1:0]}];
      own_rd <= owner_mem[qry_idx];
      fpg_rd <= fpage_mem[qry_idx];
   end

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      hit_in = hit_ff;
      hslot_in = hslot_ff;
      pages_in = pages_ff;
      pg_in = pg_ff;
      out_in = out_ff;
      ovalid_in = ovalid_ff && !rsp_ready;
      fcount_in = fcount_ff;
      pcount_in = pcount_ff;
      pop = 1'b0;
      case (state_ff)
         S_IDLE: begin
            idx_in = '0;
            hit_in = 1'b0;
            pg_in = '0;
            if (q_valid) state_in = (q_item.action == ACT_QUERY) ? S_QUERY : S_SCAN;
         end
         S_SCAN: begin
            // pid_rd holds entry idx_ff; one entry per cycle
            if ({1'b0, idx_ff} < (SW + 1)'(pcount_ff) && pid_rd == cur_ff.pid
                && !hit_ff) begin
               hit_in = 1'b1;
               hslot_in = idx_ff;
            end
            if ({1'b0, idx_ff} >= (SW + 1)'(pcount_ff) || hit_ff
                || idx_ff == SW'(MAX_PROCESSES - 1))
               state_in = S_DECIDE;
            else
               idx_in = idx_ff + SW'(1);
         end
         S_DECIDE: begin
            if (!ovalid_ff || rsp_ready) begin
               out_in = '0;
               out_in.last = 1'b1;
               if (cur_ff.action == ACT_LIST) begin
                  if (!hit_ff) begin
                     out_in.status = ST_NOTFOUND;
                     ovalid_in = 1'b1;
                     state_in = S_IDLE;
                  end else if (ppages_rd == 4'd0) begin
                     ovalid_in = 1'b1;
                     state_in = S_IDLE;
                  end else begin
                     pages_in = ppages_rd;
                     state_in = S_LIST;
                  end
               end else if (hit_ff) begin
                  out_in.status = ST_DUP;
                  ovalid_in = 1'b1;
                  state_in = S_IDLE;
               end else if (cur_ff.size_bytes > 16'(MAX_PROCESS_BYTES)) begin
                  out_in.status = ST_LARGE;
                  ovalid_in = 1'b1;
                  state_in = S_IDLE;
               end else if (17'(fcount_ff) < pages_calc) begin
                  out_in.status = ST_NOMEM;
                  out_in.num_pages = pages_calc[3:0];
                  ovalid_in = 1'b1;
                  state_in = S_IDLE;
               end else if (pcount_ff >= PCW'(MAX_PROCESSES)) begin
                  out_in.status = ST_FULL;
                  out_in.num_pages = pages_calc[3:0];
                  ovalid_in = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  pcount_in = pcount_ff + PCW'(1);
                  pages_in = pages_calc[3:0];
                  if (pages_calc == 17'd0) begin
                     ovalid_in = 1'b1;
                     state_in = S_IDLE;
                  end else
                     state_in = S_ALLOC;
               end
            end
         end
         S_ALLOC: begin
            if (!ovalid_ff || rsp_ready) begin
               pop = 1'b1;
               fcount_in = fcount_ff - CW'(1);
               out_in = '0;
               out_in.has_entry = 1'b1;
               out_in.page_number = pg_ff[2:0];
               out_in.frame_number = 5'(top_frame);
               out_in.num_pages = pages_ff;
               out_in.last = (pg_ff + 4'd1 == pages_ff);
               ovalid_in = 1'b1;
               pg_in = pg_ff + 4'd1;
               if (out_in.last) state_in = S_IDLE;
            end
         end
         S_LIST: begin
            // map_rd tracks pg_ff; after a step the state machine passes S_EMIT before the next word
            if ((!ovalid_ff || rsp_ready)) begin
               out_in = '0;
               out_in.has_entry = 1'b1;
               out_in.page_number = pg_ff[2:0];
               out_in.frame_number = 5'(map_rd);
               out_in.num_pages = pages_ff;
               out_in.last = (pg_ff + 4'd1 == pages_ff);
               ovalid_in = 1'b1;
               pg_in = pg_ff + 4'd1;
               state_in = out_in.last ? S_IDLE : S_EMIT;
            end
         end
         S_EMIT: state_in = S_LIST;
         S_QUERY: begin
            if (!ovalid_ff || rsp_ready) begin
               out_in = '0;
               out_in.last = 1'b1;
               out_in.frame_number = cur_ff.frame_index;
               if ({27'd0, cur_ff.frame_index} >= 32'(NumFrames)) begin
                  out_in.status = ST_NOTFOUND;
                  out_in.frame_number = '0;
               end else if (isfree_ff[cur_ff.frame_index[FW-1:0]]) begin
                  out_in.frame_free = 1'b1;
               end else begin
                  out_in.has_entry = 1'b1;
                  out_in.page_number = fpg_rd;
                  out_in.owner_id = own_rd;
               end
               ovalid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ovalid_ff <= 1'b0;
         fcount_ff <= CW'(NumFrames);
         pcount_ff <= '0;
         isfree_ff <= '1;
      end else begin
         state_ff <= state_in;
         ovalid_ff <= ovalid_in;
         fcount_ff <= fcount_in;
         pcount_ff <= pcount_in;
         if (pop) isfree_ff[top_frame] <= 1'b0;
      end
      if (reset) begin
         for (int i = 0; i < NumFrames; i++) stack_ff[i] <= FW'(i);
      end
      if (state_ff == S_IDLE && q_valid) cur_ff <= q_item;
      idx_ff <= idx_in;
      hit_ff <= hit_in;
      hslot_ff <= hslot_in;
      pages_ff <= pages_in;
      pg_ff <= pg_in;
      out_ff <= out_in;
      if (state_ff == S_DECIDE && state_in == S_ALLOC
          || state_ff == S_DECIDE && cur_ff.action == ACT_CREATE && pcount_in != pcount_ff) begin
         pid_mem[SW'(pcount_ff)] <= cur_ff.pid;
         ppages_mem[SW'(pcount_ff)] <= pages_calc[3:0];
      end
      if (pop) begin
         owner_mem[top_frame] <= cur_ff.pid;
         fpage_mem[top_frame] <= pg_ff[2:0];
         map_mem[{map_slot, pg_ff[PW-1:0]}] <= top_frame;
      end
   end
endmodule

/* rtl/paged_frame_allocator_top.sv */
// Top level of the paged frame allocator: front, queue and back part.
// Depends on pfa_pkg, pfa_front, pfa_fifo, pfa_back.
//
//  channel | dir | word
//  req_    | in  | action, pid, size_bytes, frame_index
//  rsp_    | out | status..owner_id in tdata, last as tlast
//
// A create or listing scans the process table one entry a cycle, then gives
// one result word a cycle while rsp_tready is high (a listing passes through
// S_EMIT between words). A frame query gives one word. Reset is synchronous
// and leaves every frame free and the table empty. Either side may stall.
module paged_frame_allocator_top #(
   parameter int MEMORY_BYTES = pfa_pkg::MemoryBytesDef,
   parameter int PAGE_BYTES = pfa_pkg::PageBytesDef,
   parameter int MAX_PROCESS_BYTES = pfa_pkg::MaxProcBytesDef,
   parameter int MAX_PROCESSES = pfa_pkg::MaxProcsDef
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [39:0] req_tdata,  // action, pid, size_bytes, frame_index
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [39:0] rsp_tdata,  // status, has_entry, page_number, frame_number,
                                   // num_pages, frame_free, owner_id
   output logic rsp_tlast
);
   import pfa_pkg::*;
   req_type req_item, fq_item, bq_item;
   rsp_type rsp_item;
   logic fq_valid, fq_ready, bq_valid, bq_ready;

   assign req_item.action = req_tdata[1:0];
   assign req_item.pid = req_tdata[17:2];
   assign req_item.size_bytes = req_tdata[33:18];
   assign req_item.frame_index = req_tdata[38:34];

   pfa_front u_front (.req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_item(req_item), .q_valid(fq_valid), .q_ready(fq_ready), .q_item(fq_item));

   pfa_fifo u_fifo (.clock(clock), .reset(reset), .in_valid(fq_valid),
      .in_ready(fq_ready), .in_data(fq_item), .out_valid(bq_valid),
      .out_ready(bq_ready), .out_data(bq_item));

   pfa_back #(.MEMORY_BYTES(MEMORY_BYTES), .PAGE_BYTES(PAGE_BYTES),
      .MAX_PROCESS_BYTES(MAX_PROCESS_BYTES), .MAX_PROCESSES(MAX_PROCESSES)) u_back (
      .clock(clock), .reset(reset), .q_valid(bq_valid), .q_ready(bq_ready),
      .q_item(bq_item), .rsp_valid(rsp_tvalid), .rsp_ready(rsp_tready),
      .rsp_item(rsp_item));

   assign rsp_tdata = {7'd0, rsp_item.owner_id, rsp_item.frame_free, rsp_item.num_pages,
      rsp_item.frame_number, rsp_item.page_number, rsp_item.has_entry,
      rsp_item.status};
   assign rsp_tlast = rsp_item.last;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed under stall");
   a_entry: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_item.has_entry |-> rsp_item.status == ST_OK)
      else $error("mapping with error status");
endmodule
